/* src/npc_pkg.sv */
`default_nettype none

package npc_pkg;

	// Palette store depth; entry_index addresses at most 256 slots.
	localparam int PALETTE_DEPTH = 256;
	localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SLOTS         = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;

	localparam int COUNT_W = 9;
	localparam int IDX_W   = 8;
	localparam int COMP_W  = 8;
	localparam int COLOR_W = 3 * COMP_W;
	localparam int DIST_W  = 29;
	localparam int TERM_W  = 27;
	localparam int WEIGHT_W = 11;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
	} color_t;

	// Tag that travels with each palette read down the distance pipeline.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot);
		slot_addr = ADDR_W'(slot);
	endfunction

endpackage

`default_nettype wire

/* src/nearest_palette_colour.sv */
`default_nettype none

// Nearest palette color search under the redmean distance (scaled by 512 so
// it is exact in integers). A word with func = 0 writes red/green/blue into
// palette slot entry_index and gives no result; slots at or beyond the
// palette depth are dropped. A word with func = 1 scans slots 0 .. n-1, n
// being the configured count clamped to 1 .. min(depth, 256), and returns
// the color and slot of the first entry with the strictly smallest
// distance. A pixel reads the palette one slot per cycle, then each entry
// passes four more distance stages, the compare stage and the output
// register; the single read port of the palette memory sets the read rate.
// The next word is taken in the cycle after the result is registered. One
// item is worked on at a time; the result sits in an output register, so
// the next item is taken while it waits. Read only palette slots that were
// written since reset. The configuration channel is always ready; write it
// only while the block is idle.

module nearest_palette_colour (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [npc_pkg::COUNT_W-1:0]    cfg_data,

	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           func,
	input  wire logic [npc_pkg::IDX_W-1:0]      entry_index,
	input  wire logic [npc_pkg::COMP_W-1:0]     red,
	input  wire logic [npc_pkg::COMP_W-1:0]     green,
	input  wire logic [npc_pkg::COMP_W-1:0]     blue,

	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [npc_pkg::COMP_W-1:0]          best_red,
	output logic [npc_pkg::COMP_W-1:0]          best_green,
	output logic [npc_pkg::COMP_W-1:0]          best_blue,
	output logic [npc_pkg::IDX_W-1:0]           best_index
);

	npc_pkg::state_t state_q, state_d;

	logic [npc_pkg::COUNT_W-1:0] count_q;
	npc_pkg::color_t             pixel_q;
	logic [npc_pkg::IDX_W-1:0]   scan_idx_q;
	logic [npc_pkg::IDX_W-1:0]   last_idx_q;
	logic [npc_pkg::IDX_W-1:0]   last_idx_d;

	npc_pkg::color_t             best_c_q;
	logic [npc_pkg::IDX_W-1:0]   best_i_q;
	logic [npc_pkg::DIST_W-1:0]  best_d_q;

	logic                        out_valid_q;
	npc_pkg::color_t             out_c_q;
	logic [npc_pkg::IDX_W-1:0]   out_i_q;

	logic in_fire, load_fire, pixel_fire, rd_en, scan_last, out_load;

	npc_pkg::tag_t               tag_s1;
	npc_pkg::color_t             entry_s1;
	npc_pkg::color_t             entry_s5;
	npc_pkg::tag_t               tag_s5;
	logic [npc_pkg::DIST_W-1:0]  dist_s5;
	logic                        take_s5;
	logic [npc_pkg::COLOR_W-1:0] rd_data;

	int unsigned count_clamped;

	assign cfg_ready  = 1'b1;
	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (func == npc_pkg::FUNC_LOAD) &&
	                    (32'(entry_index) < npc_pkg::PALETTE_DEPTH);
	assign pixel_fire = in_fire && (func == npc_pkg::FUNC_PIXEL);
	assign scan_last  = (scan_idx_q == last_idx_q);
	assign out_load   = (state_q == npc_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Clamp the entry count to 1 .. SLOTS and keep the last slot to scan.
	always_comb begin
		count_clamped = (count_q == '0) ? 1 : int'(count_q);
		if (count_clamped > npc_pkg::SLOTS) begin
			count_clamped = npc_pkg::SLOTS;
		end
		last_idx_d = npc_pkg::IDX_W'(count_clamped - 1);
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			npc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (pixel_fire) begin
					state_d = npc_pkg::ST_SCAN;
				end
			end
			npc_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = npc_pkg::ST_DRAIN;
				end
			end
			npc_pkg::ST_DRAIN: begin
				if (tag_s5.valid && tag_s5.last) begin
					state_d = npc_pkg::ST_DONE;
				end
			end
			npc_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = npc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = npc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= npc_pkg::ST_IDLE;
			count_q     <= npc_pkg::COUNT_W'(1);
			out_valid_q <= 1'b0;
			tag_s1      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			// Hold the result until the consumer takes it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			tag_s1 <= '{valid: rd_en, last: scan_last, idx: scan_idx_q};
		end
	end

	// Latch the pixel and the scan range; advance the read address.
	always_ff @(posedge clk) begin
		if (pixel_fire) begin
			pixel_q    <= '{r: red, g: green, b: blue};
			last_idx_q <= last_idx_d;
			scan_idx_q <= '0;
		end else if (rd_en) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	npc_ram #(
		.DEPTH(npc_pkg::PALETTE_DEPTH),
		.WIDTH(npc_pkg::COLOR_W)
	) u_palette (
		.clk  (clk),
		.we   (load_fire),
		.waddr(npc_pkg::slot_addr(entry_index)),
		.wdata({red, green, blue}),
		.re   (rd_en),
		.raddr(npc_pkg::slot_addr(scan_idx_q)),
		.rdata(rd_data)
	);

	assign entry_s1 = npc_pkg::color_t'(rd_data);

	npc_distance u_distance (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel_q),
		.entry_s1(entry_s1),
		.tag_s1  (tag_s1),
		.entry_s5(entry_s5),
		.tag_s5  (tag_s5),
		.dist_s5 (dist_s5)
	);

	// Slot 0 seeds the minimum; later slots replace it only when strictly closer.
	assign take_s5 = tag_s5.valid && ((tag_s5.idx == '0) || (dist_s5 < best_d_q));

	always_ff @(posedge clk) begin
		if (take_s5) begin
			best_d_q <= dist_s5;
			best_c_q <= entry_s5;
			best_i_q <= tag_s5.idx;
		end
		if (out_load) begin
			out_c_q <= best_c_q;
			out_i_q <= best_i_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_red   = out_c_q.r;
	assign best_green = out_c_q.g;
	assign best_blue  = out_c_q.b;
	assign best_index = out_i_q;

endmodule

`default_nettype wire

/* src/npc_ram.sv */
`default_nettype none

module npc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/npc_distance.sv */
`default_nettype none

module npc_distance (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire npc_pkg::color_t             pixel,
	input  wire npc_pkg::color_t             entry_s1,
	input  wire npc_pkg::tag_t               tag_s1,
	output npc_pkg::color_t                  entry_s5,
	output npc_pkg::tag_t                    tag_s5,
	output logic [npc_pkg::DIST_W-1:0]       dist_s5
);

	npc_pkg::tag_t   tag_s2, tag_s3, tag_s4;
	npc_pkg::color_t entry_s2, entry_s3, entry_s4;

	logic [npc_pkg::COMP_W-1:0]   dr_s2, dg_s2, db_s2;
	logic [npc_pkg::COMP_W:0]     sum_s2;
	logic [2*npc_pkg::COMP_W-1:0] sqr_s3, sqg_s3, sqb_s3;
	logic [npc_pkg::WEIGHT_W-1:0] wr_s3, wb_s3;
	logic [npc_pkg::TERM_W-1:0]   tr_s4, tg_s4, tb_s4;

	function automatic logic [npc_pkg::COMP_W-1:0] absdiff(
		input logic [npc_pkg::COMP_W-1:0] a,
		input logic [npc_pkg::COMP_W-1:0] b
	);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	// Advance the tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		entry_s2 <= entry_s1;
		entry_s3 <= entry_s2;
		entry_s4 <= entry_s3;
		entry_s5 <= entry_s4;

		dr_s2  <= absdiff(pixel.r, entry_s1.r);
		dg_s2  <= absdiff(pixel.g, entry_s1.g);
		db_s2  <= absdiff(pixel.b, entry_s1.b);
		sum_s2 <= {1'b0, pixel.r} + {1'b0, entry_s1.r};

		sqr_s3 <= (2*npc_pkg::COMP_W)'(dr_s2) * (2*npc_pkg::COMP_W)'(dr_s2);
		sqg_s3 <= (2*npc_pkg::COMP_W)'(dg_s2) * (2*npc_pkg::COMP_W)'(dg_s2);
		sqb_s3 <= (2*npc_pkg::COMP_W)'(db_s2) * (2*npc_pkg::COMP_W)'(db_s2);
		wr_s3  <= 11'd1024 + {2'b00, sum_s2};
		wb_s3  <= 11'd1536 - {2'b00, sum_s2};

		tr_s4 <= npc_pkg::TERM_W'(wr_s3) * npc_pkg::TERM_W'(sqr_s3);
		tg_s4 <= {sqg_s3, 11'b0};
		tb_s4 <= npc_pkg::TERM_W'(wb_s3) * npc_pkg::TERM_W'(sqb_s3);

		dist_s5 <= npc_pkg::DIST_W'(tr_s4) + npc_pkg::DIST_W'(tg_s4) +
		           npc_pkg::DIST_W'(tb_s4);
	end

endmodule

`default_nettype wire

/* tb/palette_match_checker.sv */
`timescale 1ns / 100ps

module palette_match_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        cfg_valid,
	input  wire logic                        cfg_ready,
	input  wire logic [npc_pkg::COUNT_W-1:0] cfg_data,

	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic                        func,
	input  wire logic [npc_pkg::IDX_W-1:0]   entry_index,
	input  wire logic [npc_pkg::COMP_W-1:0]  red,
	input  wire logic [npc_pkg::COMP_W-1:0]  green,
	input  wire logic [npc_pkg::COMP_W-1:0]  blue,

	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [npc_pkg::COMP_W-1:0]  best_red,
	input  wire logic [npc_pkg::COMP_W-1:0]  best_green,
	input  wire logic [npc_pkg::COMP_W-1:0]  best_blue,
	input  wire logic [npc_pkg::IDX_W-1:0]   best_index,

	output int                               errors,
	output int                               pending,
	output int                               checked
);

	localparam int INDEX_REACH = 1 << npc_pkg::IDX_W;

	typedef struct packed {
		npc_pkg::color_t             shade;
		logic [npc_pkg::IDX_W-1:0]   slot;
	} match_t;

	npc_pkg::color_t             palette_copy [npc_pkg::PALETTE_DEPTH];
	logic [npc_pkg::COUNT_W-1:0] search_count;
	match_t                      quantized_q [$];
	match_t                      want;

	// Redmean distance, scaled by 512 so every term stays integral.
	function automatic longint unsigned redmean_cost(input npc_pkg::color_t a,
			input npc_pkg::color_t b);
		longint unsigned s, dr, dg, db;
		s  = a.r + b.r;
		dr = (a.r > b.r) ? a.r - b.r : b.r - a.r;
		dg = (a.g > b.g) ? a.g - b.g : b.g - a.g;
		db = (a.b > b.b) ? a.b - b.b : b.b - a.b;
		return 2048 * dg * dg + (1024 + s) * dr * dr + (1536 - s) * db * db;
	endfunction

	// Scan the live part of the palette; only a strictly smaller cost moves the winner.
	function automatic match_t nearest_match(input npc_pkg::color_t px);
		int              n;
		int              i;
		longint unsigned best_cost;
		longint unsigned cost;
		match_t          best;
		n = search_count;
		if (n < 1)
			n = 1;
		if (n > npc_pkg::PALETTE_DEPTH)
			n = npc_pkg::PALETTE_DEPTH;
		if (n > INDEX_REACH)
			n = INDEX_REACH;
		best.shade = palette_copy[0];
		best.slot  = '0;
		best_cost  = redmean_cost(px, palette_copy[0]);
		for (i = 1; i < n; i++) begin
			cost = redmean_cost(px, palette_copy[i]);
			if (cost < best_cost) begin
				best_cost  = cost;
				best.shade = palette_copy[i];
				best.slot  = npc_pkg::IDX_W'(i);
			end
		end
		return best;
	endfunction

	task automatic flag(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_count = npc_pkg::COUNT_W'(1);
			quantized_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				search_count = cfg_data;

			// Retire before predicting: a result leaving on this edge belongs to an older word.
			if (out_valid && out_ready) begin
				if (quantized_q.size() == 0) begin
					flag($sformatf("result %0d/%0d/%0d slot %0d with nothing expected",
						best_red, best_green, best_blue, best_index));
				end else begin
					want = quantized_q.pop_front();
					checked++;
					if (best_red !== want.shade.r)
						flag($sformatf("result %0d: best_red %0d, expected %0d",
							checked, best_red, want.shade.r));
					if (best_green !== want.shade.g)
						flag($sformatf("result %0d: best_green %0d, expected %0d",
							checked, best_green, want.shade.g));
					if (best_blue !== want.shade.b)
						flag($sformatf("result %0d: best_blue %0d, expected %0d",
							checked, best_blue, want.shade.b));
					if (best_index !== want.slot)
						flag($sformatf("result %0d: best_index %0d, expected %0d",
							checked, best_index, want.slot));
				end
			end

			if (in_valid && in_ready) begin
				if (func == npc_pkg::FUNC_LOAD) begin
					if (entry_index < npc_pkg::PALETTE_DEPTH)
						palette_copy[entry_index] = {red, green, blue};
				end else begin
					quantized_q.push_back(nearest_match({red, green, blue}));
				end
			end

			pending <= quantized_q.size();
		end
	end

endmodule

/* tb/tb_nearest_palette_colour.sv */
`timescale 1ns / 100ps

module tb_nearest_palette_colour;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int ITEM_GOAL    = 2000;
	// Longest quiet stretch of a correct run is a full 256-entry scan plus
	// pipeline, a receiver stall and a sender gap.
	localparam int STALL_LIMIT  = 2000;
	// Pause before a register write: a trailing load word may still be in flight.
	localparam int SETTLE_CYCLES = 16;
	// Watch for stray results after the last expected one.
	localparam int TAIL_CYCLES  = 2 * (npc_pkg::PALETTE_DEPTH + 7);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                        cfg_valid = 1'b0;
	logic [npc_pkg::COUNT_W-1:0] cfg_data  = '0;
	logic                        cfg_ready;

	logic                        in_valid    = 1'b0;
	logic                        func        = npc_pkg::FUNC_LOAD;
	logic [npc_pkg::IDX_W-1:0]   entry_index = '0;
	logic [npc_pkg::COMP_W-1:0]  red         = '0;
	logic [npc_pkg::COMP_W-1:0]  green       = '0;
	logic [npc_pkg::COMP_W-1:0]  blue        = '0;
	logic                        in_ready;

	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [npc_pkg::COMP_W-1:0]  best_red;
	logic [npc_pkg::COMP_W-1:0]  best_green;
	logic [npc_pkg::COMP_W-1:0]  best_blue;
	logic [npc_pkg::IDX_W-1:0]   best_index;

	int mismatch_count;
	int results_due;
	int results_checked;

	// Stimulus bookkeeping: a copy of what was loaded, used only to aim pixels
	// at palette colors and to plant duplicate colors for tie cases.
	npc_pkg::color_t shade_copy [npc_pkg::SLOTS];
	int              burst_left    = 0;
	int              loads_sent    = 0;
	int              pixels_sent   = 0;
	int              settings_made = 0;
	int              idle_cycles   = 0;
	int              ready_left    = 0;

	wire word_moved = (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
		(out_valid && out_ready);

	always #(HALF_PERIOD) clk = ~clk;

	nearest_palette_colour uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_red    (best_red),
		.best_green  (best_green),
		.best_blue   (best_blue),
		.best_index  (best_index)
	);

	palette_match_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_red    (best_red),
		.best_green  (best_green),
		.best_blue   (best_blue),
		.best_index  (best_index),
		.errors      (mismatch_count),
		.pending     (results_due),
		.checked     (results_checked)
	);

	// Receiver: long ready stretches broken by stalls of varying length.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				out_ready  <= 1'b1;
				ready_left <= $urandom_range(1, 40);
			end else begin
				out_ready  <= 1'b0;
				ready_left <= $urandom_range(1, 15);
			end
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	// Watchdog: end the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (word_moved) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mostly random components, with the rails 0 and 255 showing up often.
	function automatic logic [7:0] pick_component();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic npc_pkg::color_t rand_shade();
		npc_pkg::color_t c;
		c.r = pick_component();
		c.g = pick_component();
		c.b = pick_component();
		return c;
	endfunction

	// Jitter a component by a few steps, clamped to the 8-bit range.
	function automatic logic [7:0] nudge(input logic [7:0] c);
		int t;
		t = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	// Number of slots a pixel actually scans for a given register value.
	function automatic int search_span(input int v);
		int n;
		n = (v == 0) ? 1 : v;
		if (n > npc_pkg::SLOTS)
			n = npc_pkg::SLOTS;
		return n;
	endfunction

	// Offer one word; call right after a rising edge. Bursts of random length
	// are separated by random gaps, some of them zero so bursts run back to back.
	task automatic push_word(input logic op, input logic [7:0] slot,
			input npc_pkg::color_t shade);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 5))
				0, 1: gap = 0;
				2: gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 5);
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		func        <= op;
		entry_index <= slot;
		red         <= shade.r;
		green       <= shade.g;
		blue        <= shade.b;
		// Hold the word until the block takes it.
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic load(input int slot, input npc_pkg::color_t shade);
		push_word(npc_pkg::FUNC_LOAD, 8'(slot), shade);
		shade_copy[slot] = shade;
		loads_sent++;
	endtask

	// The slot field is don't-care for pixels: fill it with noise.
	task automatic pixel(input npc_pkg::color_t shade);
		push_word(npc_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)), shade);
		pixels_sent++;
	endtask

	// Drop valid, wait for every expected result, then give trailing loads time.
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the search count while the block is idle.
	task automatic write_count(input int v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= npc_pkg::COUNT_W'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		settings_made++;
	endtask

	initial begin
		npc_pkg::color_t shade;
		int              phase;
		int              count_val;
		int              span;
		int              phase_len;
		int              k;
		int              i;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset count is 1: only slot 0 is searched.
		load(0, {8'd0, 8'd0, 8'd0});
		pixel({8'd0, 8'd0, 8'd0});
		pixel({8'd255, 8'd255, 8'd255});

		// A count of zero still searches one slot.
		write_count(0);
		load(255, {8'd1, 8'd2, 8'd3});
		load(1, {8'd255, 8'd255, 8'd255});
		load(2, {8'd0, 8'd0, 8'd0});         // same color as slot 0: tie
		load(3, {8'd255, 8'd0, 8'd0});
		load(4, {8'd0, 8'd255, 8'd0});
		load(5, {8'd0, 8'd0, 8'd255});
		load(6, {8'd128, 8'd128, 8'd128});
		pixel({8'd255, 8'd255, 8'd255});     // exact hit in slot 1, but unsearched

		write_count(7);
		pixel({8'd0, 8'd0, 8'd0});           // tie between slots 0 and 2: lower wins
		pixel({8'd255, 8'd255, 8'd255});
		pixel({8'd254, 8'd1, 8'd0});
		pixel({8'd0, 8'd255, 8'd0});
		pixel({8'd0, 8'd0, 8'd255});
		pixel({8'd127, 8'd128, 8'd129});
		pixel({8'd255, 8'd255, 8'd0});
		pixel({8'd0, 8'd128, 8'd255});       // red weight low, blue weight high

		// Fill every slot so any count is safe; plant duplicate colors for ties.
		for (i = 0; i < npc_pkg::SLOTS; i++) begin
			if (i > 0 && $urandom_range(0, 7) == 0)
				load(i, shade_copy[$urandom_range(0, i - 1)]);
			else
				load(i, rand_shade());
		end

		// Random phases, each under its own count setting. Large counts make
		// pixels slow, so those phases are kept short.
		phase = 0;
		while (loads_sent + pixels_sent < ITEM_GOAL) begin
			case (phase % 8)
				0: count_val = 511;
				1: count_val = $urandom_range(2, 16);
				2: count_val = 0;
				3: count_val = $urandom_range(1, 40);
				4: count_val = 256;
				5: count_val = $urandom_range(2, 8);
				6: count_val = (phase % 16 == 6) ? 255 : 257;
				default: count_val = $urandom_range(41, 128);
			endcase
			write_count(count_val);
			span = search_span(count_val);
			phase_len = (span >= 128) ? $urandom_range(40, 70) : $urandom_range(150, 250);

			for (k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					// Overwrite a slot, sometimes with a color already in the palette.
					if ($urandom_range(0, 3) == 0)
						shade = shade_copy[$urandom_range(0, npc_pkg::SLOTS - 1)];
					else
						shade = rand_shade();
					load($urandom_range(0, npc_pkg::SLOTS - 1), shade);
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: shade = rand_shade();
						4, 5, 6: begin
							// Land close to a searched entry.
							shade = shade_copy[$urandom_range(0, span - 1)];
							shade.r = nudge(shade.r);
							shade.g = nudge(shade.g);
							shade.b = nudge(shade.b);
						end
						7, 8: shade = shade_copy[$urandom_range(0, span - 1)];
						default: shade = npc_pkg::COLOR_W'($urandom());
					endcase
					pixel(shade);
				end
			end
			phase++;
		end

		// Drain, then watch a while longer for stray results.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d palette loads and %0d pixel lookups over %0d count settings.",
			loads_sent, pixels_sent, settings_made);
		$display("%0d results compared, %0d mismatches, %0d still outstanding.",
			results_checked, mismatch_count, results_due);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* nearest_palette_colour.f */
src/npc_pkg.sv
src/npc_ram.sv
src/npc_distance.sv
src/nearest_palette_colour.sv
tb/palette_match_checker.sv
tb/tb_nearest_palette_colour.sv
